// File: src/lcma_pkg.sv
// Shared constants, types and derived widths for the load cell moving average block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package lcma_pkg;

    // Filter geometry and field widths.
    localparam int TAPS        = 6;
    localparam int SAMPLE_BITS = 12;
    localparam int NCH         = 3;
    localparam int REG_W       = 12;
    localparam int FORCE_W     = 16;
    localparam int FRAC_BITS   = 8;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_W  = ((NCH * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((NCH * FORCE_W + 7) / 8) * 8;

    // Datapath widths derived from the geometry.
    localparam int SUM_W  = $clog2(TAPS * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int OFFM_W = $clog2(TAPS * ((1 << REG_W) - 1) + 1);
    localparam int D_W    = ((SUM_W > OFFM_W) ? SUM_W : OFFM_W) + 1;
    localparam int P_W    = D_W + REG_W + 1;
    localparam int M_W    = P_W - FRAC_BITS;
    localparam int L_W    = $clog2(TAPS);
    localparam int Q_W    = M_W - L_W + 1;
    localparam int R_W    = M_W + 1;
    localparam int SHIFT  = M_W + L_W;

    // Reciprocal of the tap count, rounded up, exact for every M_W-bit dividend.
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + TAPS - 1) / TAPS;

    // Saturation bounds.
    localparam logic [Q_W-1:0] Q_POS_LIM = Q_W'((1 << (FORCE_W - 1)) - 1);
    localparam logic [Q_W-1:0] Q_NEG_LIM = Q_W'(1 << (FORCE_W - 1));
    localparam logic signed [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W - 1){1'b1}}};
    localparam logic signed [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W - 1){1'b0}}};

    // Register reset values.
    localparam logic [REG_W-1:0] OFFSET_CH0_RST = REG_W'(1960);
    localparam logic [REG_W-1:0] OFFSET_CH1_RST = REG_W'(2016);
    localparam logic [REG_W-1:0] OFFSET_CH2_RST = REG_W'(1860);
    localparam logic [REG_W-1:0] GAIN_RST       = REG_W'(367);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [NCH-1:0][SAMPLE_BITS-1:0] sample_vec_t;
    typedef logic [REG_W-1:0] cfg_reg_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_OFFSET_CH0 = 2'd0,
        CFG_OFFSET_CH1 = 2'd1,
        CFG_OFFSET_CH2 = 2'd2,
        CFG_GAIN       = 2'd3
    } cfg_idx_t;

    // Stage enables handed from the control pipeline to each channel datapath.
    typedef struct packed {
        logic acc;
        logic prime;
        logic en_d;
        logic en_p;
        logic en_m;
        logic en_q;
        logic en_o;
    } stg_ctrl_t;

endpackage

// File: src/load_cell_moving_average.sv
// Top level of the three-channel load cell moving average: delay line, control, config.
// Depends on lcma_pkg, lcma_tap_cell and lcma_chan_scale.
`timescale 1ns / 1ps

// The block takes one item of three 12-bit sensor samples per cycle and gives one item
// of three signed integer forces, each the mean of the last six samples less the channel
// offset, times the Q8 gain, saturated to 16 bits. The first item after reset fills the
// whole window with its samples. A result passes the sum, offset, gain, magnitude,
// divide and output registers in turn, and a new item can be accepted in every cycle
// while the master side keeps up: the window sum is a running sum updated from a
// six-cell delay line, and the offset, gain, reciprocal divide and saturation each sit
// in a pipeline stage of their own. Each stage holds its item while the master side
// stalls, so the slave side keeps accepting until all six stages are full. Configuration
// writes take effect at once and are meant to be made while no item is in flight.
module load_cell_moving_average import lcma_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    // Slave side; s_tdata fields from bit 0: sample_ch0, sample_ch1, sample_ch2.
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    // Master side; m_tdata fields from bit 0: force_ch0, force_ch1, force_ch2.
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    // Configuration write port.
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [REG_W-1:0] cfg_wr_data
);

    cfg_reg_t offset_reg [NCH];
    cfg_reg_t gain_reg;
    logic     primed_reg;
    logic     v_s_reg, v_d_reg, v_p_reg, v_m_reg, v_q_reg, v_o_reg;
    logic     rdy_s, rdy_d, rdy_p, rdy_m, rdy_q, rdy_o;
    stg_ctrl_t ctrl;
    sample_vec_t new_vec;
    sample_vec_t tap_q [TAPS];
    logic [NCH-1:0][FORCE_W-1:0] force_vec;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg[0] <= OFFSET_CH0_RST;
            offset_reg[1] <= OFFSET_CH1_RST;
            offset_reg[2] <= OFFSET_CH2_RST;
            gain_reg      <= GAIN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_OFFSET_CH0: offset_reg[0] <= cfg_wr_data;
                CFG_OFFSET_CH1: offset_reg[1] <= cfg_wr_data;
                CFG_OFFSET_CH2: offset_reg[2] <= cfg_wr_data;
                CFG_GAIN:       gain_reg      <= cfg_wr_data;
            endcase
        end
    end

    // Ready chain: a stage can take an item when it is empty or passing its item on.
    assign rdy_o = !v_o_reg || m_tready;
    assign rdy_q = !v_q_reg || rdy_o;
    assign rdy_m = !v_m_reg || rdy_q;
    assign rdy_p = !v_p_reg || rdy_m;
    assign rdy_d = !v_d_reg || rdy_p;
    assign rdy_s = !v_s_reg || rdy_d;

    // No item is taken while reset is asserted.
    assign s_tready   = rdy_s && aresetn;
    assign ctrl.acc   = s_tvalid && s_tready;
    assign ctrl.prime = !primed_reg;
    assign ctrl.en_d  = v_s_reg && rdy_d;
    assign ctrl.en_p  = v_d_reg && rdy_p;
    assign ctrl.en_m  = v_p_reg && rdy_m;
    assign ctrl.en_q  = v_m_reg && rdy_q;
    assign ctrl.en_o  = v_q_reg && rdy_o;

    // Stage valid bits and the primed flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
            v_s_reg    <= 1'b0;
            v_d_reg    <= 1'b0;
            v_p_reg    <= 1'b0;
            v_m_reg    <= 1'b0;
            v_q_reg    <= 1'b0;
            v_o_reg    <= 1'b0;
        end else begin
            if (ctrl.acc) begin
                primed_reg <= 1'b1;
            end
            v_s_reg <= ctrl.acc  || (v_s_reg && !rdy_d);
            v_d_reg <= ctrl.en_d || (v_d_reg && !rdy_p);
            v_p_reg <= ctrl.en_p || (v_p_reg && !rdy_m);
            v_m_reg <= ctrl.en_m || (v_m_reg && !rdy_q);
            v_q_reg <= ctrl.en_q || (v_q_reg && !rdy_o);
            v_o_reg <= ctrl.en_o || (v_o_reg && !m_tready);
        end
    end

    assign new_vec = s_tdata[NCH*SAMPLE_BITS-1:0];

    // Delay line of cells, newest sample in cell zero.
    for (genvar k = 0; k < TAPS; k++) begin : g_tap
        if (k == 0) begin : g_first
            lcma_tap_cell u_cell (
                .aclk     (aclk),
                .shift_en (ctrl.acc),
                .prime    (ctrl.prime),
                .new_in   (new_vec),
                .prev_in  (new_vec),
                .tap_out  (tap_q[k])
            );
        end else begin : g_rest
            lcma_tap_cell u_cell (
                .aclk     (aclk),
                .shift_en (ctrl.acc),
                .prime    (ctrl.prime),
                .new_in   (new_vec),
                .prev_in  (tap_q[k-1]),
                .tap_out  (tap_q[k])
            );
        end
    end

    // One scaling datapath per channel.
    for (genvar c = 0; c < NCH; c++) begin : g_chan
        lcma_chan_scale u_scale (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .new_sample (new_vec[c]),
            .oldest     (tap_q[TAPS-1][c]),
            .offset     (offset_reg[c]),
            .gain       (gain_reg),
            .force_out  (force_vec[c])
        );
    end

    assign m_tvalid = v_o_reg;
    assign m_tdata  = OUT_W'(force_vec);

    // Any accepted item leaves the window primed.
    a_primed_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.acc |=> primed_reg)
        else $error("window not primed after an accepted item");

    // The slave side only stalls when every stage holds an item.
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v_s_reg && v_d_reg && v_p_reg && v_m_reg && v_q_reg && v_o_reg))
        else $error("slave side stalled with a free pipeline stage");

    // A finished item moves into an empty output register straight away.
    a_output_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_q_reg && !v_o_reg) |=> v_o_reg)
        else $error("finished item did not reach the empty output register");

    // A taken result with nothing behind it leaves the output empty.
    a_output_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_o_reg && m_tready && !v_q_reg) |=> !v_o_reg)
        else $error("output register still valid after its item was taken");

endmodule

// File: src/lcma_tap_cell.sv
// One cell of the sample delay line: holds one sample of each channel.
// Depends on lcma_pkg.
`timescale 1ns / 1ps

module lcma_tap_cell import lcma_pkg::*; (
    input  logic        aclk,
    input  logic        shift_en,
    input  logic        prime,
    input  sample_vec_t new_in,
    input  sample_vec_t prev_in,
    output sample_vec_t tap_out
);

    sample_vec_t tap_reg;
    sample_vec_t tap_next;

    // On the first item every cell takes the new samples; afterwards it takes its neighbour's.
    always_comb begin
        tap_next = tap_reg;
        if (shift_en) begin
            tap_next = prime ? new_in : prev_in;
        end
    end

    always_ff @(posedge aclk) begin
        tap_reg <= tap_next;
    end

    assign tap_out = tap_reg;

endmodule

// File: src/lcma_chan_scale.sv
// Per-channel datapath: running window sum, offset removal, gain, scaling and saturation.
// Depends on lcma_pkg; stage enables come from the top level.
`timescale 1ns / 1ps

module lcma_chan_scale import lcma_pkg::*; (
    input  logic                      aclk,
    input  stg_ctrl_t                 ctrl,
    input  sample_t                   new_sample,
    input  sample_t                   oldest,
    input  cfg_reg_t                  offset,
    input  cfg_reg_t                  gain,
    output logic signed [FORCE_W-1:0] force_out
);

    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic signed [D_W-1:0]       d_reg, d_next;
    logic signed [P_W-1:0]       p_reg, p_next;
    logic [M_W-1:0]              m_reg, m_next;
    logic                        neg_m_reg, neg_q_reg;
    logic [Q_W-1:0]              q_reg, q_next;
    logic signed [FORCE_W-1:0]   force_reg, force_next;
    logic [OFFM_W-1:0]           toff;
    logic [P_W-1:0]              mag;
    logic [M_W+R_W-1:0]          prod;

    // Running window sum: add the newest sample, drop the one leaving the delay line.
    always_comb begin
        sum_next = sum_reg;
        if (ctrl.acc) begin
            if (ctrl.prime) begin
                sum_next = SUM_W'(new_sample) * SUM_W'(TAPS);
            end else begin
                sum_next = sum_reg + SUM_W'(new_sample) - SUM_W'(oldest);
            end
        end
    end

    // Remove the zero-load offset, then apply the gain.
    assign toff   = OFFM_W'(offset) * OFFM_W'(TAPS);
    assign d_next = $signed(D_W'(sum_reg)) - $signed(D_W'(toff));
    assign p_next = P_W'(d_reg) * P_W'($signed({1'b0, gain}));

    // Magnitude and drop the Q8 fraction scale.
    assign mag    = p_reg[P_W-1] ? P_W'(-p_reg) : P_W'(p_reg);
    assign m_next = mag[P_W-1:FRAC_BITS];

    // Divide by the tap count through the reciprocal.
    assign prod   = (M_W + R_W)'(m_reg) * (M_W + R_W)'(RECIP);
    assign q_next = prod[SHIFT +: Q_W];

    // Restore the sign and saturate to the output width.
    always_comb begin
        if (neg_q_reg) begin
            if (q_reg > Q_NEG_LIM) begin
                force_next = FORCE_MIN;
            end else begin
                force_next = -$signed(FORCE_W'(q_reg));
            end
        end else if (q_reg > Q_POS_LIM) begin
            force_next = FORCE_MAX;
        end else begin
            force_next = $signed(FORCE_W'(q_reg));
        end
    end

    // Pipeline registers, each advancing on its own stage enable.
    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        if (ctrl.en_d) begin
            d_reg <= d_next;
        end
        if (ctrl.en_p) begin
            p_reg <= p_next;
        end
        if (ctrl.en_m) begin
            m_reg     <= m_next;
            neg_m_reg <= p_reg[P_W-1];
        end
        if (ctrl.en_q) begin
            q_reg     <= q_next;
            neg_q_reg <= neg_m_reg;
        end
        if (ctrl.en_o) begin
            force_reg <= force_next;
        end
    end

    assign force_out = force_reg;

endmodule

// File: bench/tb_load_cell_moving_average.sv
// Self-checking testbench for the three-channel load cell moving average block.
// Streams sample items through the block, predicts every force item and checks them.
// Depends on lcma_pkg and load_cell_moving_average.
`timescale 1ns / 1ps

module tb_load_cell_moving_average;
    import lcma_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 229;
    localparam int REPORT_LIMIT  = 10;
    localparam int HOLD_SPACING  = 900;

    typedef logic [NCH-1:0][FORCE_W-1:0] force_vec_t;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata     = '0;
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_wr_en   = 1'b0;
    logic [1:0]       cfg_index   = CFG_OFFSET_CH0;
    logic [REG_W-1:0] cfg_wr_data = '0;

    // Items waiting to be sent, and forces waiting to come back.
    sample_vec_t sample_queue[$];
    force_vec_t  force_queue[$];

    // Shadow of the configuration registers and of the averaging window.
    cfg_reg_t    offset_shadow [NCH] = '{OFFSET_CH0_RST, OFFSET_CH1_RST, OFFSET_CH2_RST};
    cfg_reg_t    gain_shadow         = GAIN_RST;
    sample_t     window [NCH][TAPS];
    int          slot_ptr            = 0;
    bit          window_filled       = 1'b0;
    sample_vec_t last_item           = '0;

    int mismatch_count = 0;
    int results_seen   = 0;
    int quiet_cycles   = 0;

    load_cell_moving_average dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Updates the window with one accepted item and works out the three forces.
    function automatic force_vec_t compute_forces(sample_vec_t smp);
        force_vec_t    f;
        longint signed total;
        longint signed q;
        for (int ch = 0; ch < NCH; ch++) begin
            if (!window_filled) begin
                for (int t = 0; t < TAPS; t++) window[ch][t] = smp[ch];
            end
            window[ch][slot_ptr] = smp[ch];
        end
        window_filled = 1'b1;
        slot_ptr = (slot_ptr == TAPS - 1) ? 0 : slot_ptr + 1;
        for (int ch = 0; ch < NCH; ch++) begin
            total = 0;
            for (int t = 0; t < TAPS; t++) total += longint'(window[ch][t]);
            // Signed division truncates toward zero, as the block must.
            q = (total - longint'(TAPS) * longint'(offset_shadow[ch]))
                * longint'(gain_shadow) / longint'(TAPS * 256);
            if (q > longint'(FORCE_MAX)) q = longint'(FORCE_MAX);
            if (q < longint'(FORCE_MIN)) q = longint'(FORCE_MIN);
            f[ch] = q[FORCE_W-1:0];
        end
        return f;
    endfunction

    function automatic void queue_samples(int a, int b, int c);
        sample_vec_t v;
        v[0] = sample_t'(a);
        v[1] = sample_t'(b);
        v[2] = sample_t'(c);
        sample_queue.push_back(v);
    endfunction

    // Half the samples lie around the zero-load code so the forces stay in range, with
    // full-scale noise, rail values and held values making up the rest.
    function automatic void queue_random_item();
        sample_vec_t v;
        int          near;
        int          delta;
        for (int ch = 0; ch < NCH; ch++) begin
            delta = int'($urandom_range(0, 800)) - 400;
            near  = int'(offset_shadow[ch]) + delta;
            if (near < 0) near = 0;
            if (near > 4095) near = 4095;
            case ($urandom_range(0, 9)) inside
                [0:4]:   v[ch] = sample_t'(near);
                [5:7]:   v[ch] = sample_t'($urandom);
                8:       v[ch] = $urandom_range(0, 1) ? '1 : '0;
                default: v[ch] = last_item[ch];
            endcase
        end
        last_item = v;
        sample_queue.push_back(v);
    endfunction

    function automatic cfg_reg_t random_offset();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return cfg_reg_t'($urandom);
        endcase
    endfunction

    function automatic cfg_reg_t random_gain();
        case ($urandom_range(0, 7)) inside
            0:       return '0;
            1:       return '1;
            2:       return GAIN_RST;
            [3:4]:   return cfg_reg_t'($urandom_range(1, 64));
            default: return cfg_reg_t'($urandom);
        endcase
    endfunction

    // Writes all four registers on consecutive edges; only called while idle.
    task automatic load_config(input cfg_reg_t off0, input cfg_reg_t off1,
                               input cfg_reg_t off2, input cfg_reg_t gain);
        cfg_idx_t order [4];
        cfg_reg_t vals  [4];
        order = '{CFG_OFFSET_CH0, CFG_OFFSET_CH1, CFG_OFFSET_CH2, CFG_GAIN};
        vals  = '{off0, off1, off2, gain};
        for (int i = 0; i < 4; i++) begin
            @(posedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_index   <= order[i];
            cfg_wr_data <= vals[i];
            case (order[i])
                CFG_OFFSET_CH0: offset_shadow[0] = vals[i];
                CFG_OFFSET_CH1: offset_shadow[1] = vals[i];
                CFG_OFFSET_CH2: offset_shadow[2] = vals[i];
                CFG_GAIN:       gain_shadow      = vals[i];
            endcase
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Waits until every item has been sent and every force has come back.
    // The check runs on the falling edge, once the rising-edge updates have settled.
    task automatic wait_idle();
        while (sample_queue.size() != 0 || s_tvalid || force_queue.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Stimulus sequence.
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration; the first item fills the whole window.
        queue_samples(4095, 0, 2730);
        queue_samples(0, 4095, 1365);
        queue_samples(2730, 1365, 4095);
        queue_samples(1960, 2016, 1860);
        queue_samples(1961, 2015, 1859);
        queue_samples(1959, 2017, 1861);
        wait_idle();

        // Zero offsets and full gain drive every channel into positive saturation.
        load_config('0, '0, '0, '1);
        repeat (5) queue_samples(4095, 4095, 4095);
        queue_samples(0, 0, 0);
        wait_idle();

        // Full offsets with an empty window give negative saturation.
        load_config('1, '1, '1, '1);
        repeat (6) queue_samples(0, 0, 0);
        wait_idle();

        // Small differences show truncation toward zero on both signs.
        load_config('0, '0, cfg_reg_t'(1), '1);
        queue_samples(1, 0, 0);
        wait_idle();

        // A gain of zero forces every output to zero.
        load_config(cfg_reg_t'(1234), '1, '0, '0);
        queue_samples(4095, 0, 4095);
        queue_samples(0, 4095, 0);
        wait_idle();

        // Random phases, each under a fresh configuration.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            load_config(random_offset(), random_offset(), random_offset(), random_gain());
            for (int n = 0; n < PHASE_ITEMS; n++) queue_random_item();
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                force_queue.push_back(compute_forces(s_tdata[NCH*SAMPLE_BITS-1:0]));
            end
            if (s_tvalid && !s_tready) begin
                // The offered item stays on the bus until it is taken.
            end else if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left--;
            end else if (sample_queue.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= IN_W'(sample_queue.pop_front());
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                             : $urandom_range(1, 40);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        1:       gap_left = $urandom_range(1, 3);
                        default: gap_left = $urandom_range(1, 12);
                    endcase
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: its own stall pattern, plus a long hold now and then so the
    // pipeline fills and pushes back on the sender.
    int ready_mode   = 0;
    int mode_left    = 0;
    int hold_left    = 0;
    int next_hold_at = 500;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_left == 0 && results_seen >= next_hold_at) begin
                hold_left = $urandom_range(120, 200);
                next_hold_at += HOLD_SPACING;
            end
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(32, 256);
            end else begin
                mode_left--;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (ready_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 9) < 7);
                    2:       m_tready <= ($urandom_range(0, 9) < 3);
                    default: m_tready <= (mode_left % 3 == 0);
                endcase
            end
        end
    end

    // Monitor: compares every accepted force item with the oldest prediction.
    always @(posedge aclk) begin
        force_vec_t got;
        force_vec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[NCH*FORCE_W-1:0];
            if (force_queue.size() == 0) begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("Unexpected force item %h at result %0d", got, results_seen);
                mismatch_count++;
            end else begin
                want = force_queue.pop_front();
                for (int ch = 0; ch < NCH; ch++) begin
                    if (got[ch] !== want[ch]) begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("force_ch%0d mismatch at result %0d: expected %0d, got %0d",
                                     ch, results_seen, $signed(want[ch]), $signed(got[ch]));
                        mismatch_count++;
                    end
                end
            end
            results_seen <= results_seen + 1;
        end
    end

    // Watchdog: counts cycles in which nothing moves on any port.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
src/lcma_pkg.sv
src/lcma_tap_cell.sv
src/lcma_chan_scale.sv
src/load_cell_moving_average.sv
bench/tb_load_cell_moving_average.sv
